// ===== rtl/stu_pkg.sv =====
// shared types and constants for the 8n1 uart transceiver
`timescale 1ns / 1ps
package stu_pkg;

	localparam int TICKS_PER_BIT_DEF = 8;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_SEND = 2'd1;
	localparam logic [1:0] REQ_RECV = 2'd2;

	localparam logic [3:0] POS_START = 4'd0;
	localparam logic [3:0] POS_DATA_FIRST = 4'd1;
	localparam logic [3:0] POS_DATA_LAST = 4'd8;
	localparam logic [3:0] POS_STOP = 4'd9;
	localparam logic [3:0] POS_FRAME_END = 4'd10;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TX   = 2'd1,
		MODE_RX   = 2'd2
	} mode_t;

	typedef struct packed {
		logic       tx_line;
		logic       tx_done;
		logic       rx_done;
		logic [7:0] rx_byte;
		logic [1:0] mode_now;
	} stu_result_t;

endpackage

// ===== rtl/stu_req_if.sv =====
// request channel: valid/ready handshake with the request fields
`timescale 1ns / 1ps
interface stu_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] tx_byte;
	logic       rx_line;

	modport source (output valid, req_type, tx_byte, rx_line, input ready);
	modport sink (input valid, req_type, tx_byte, rx_line, output ready);
endinterface

// ===== rtl/stu_res_if.sv =====
// result channel: valid/ready handshake with the result fields
`timescale 1ns / 1ps
interface stu_res_if;
	logic       valid;
	logic       ready;
	logic       tx_line;
	logic       tx_done;
	logic       rx_done;
	logic [7:0] rx_byte;
	logic [1:0] mode_now;

	modport source (output valid, tx_line, tx_done, rx_done, rx_byte, mode_now, input ready);
	modport sink (input valid, tx_line, tx_done, rx_done, rx_byte, mode_now, output ready);
endinterface

// ===== rtl/soft_uart_8n1_transceiver.sv =====
// top level of the half-duplex 8n1 uart transceiver
// an accepted item's result is registered in the result buffer before it shows on the result channel
// throughput: one item per cycle while the result buffer has room, set by the single-pass frame state update
// a two-entry result buffer keeps the request side ready for one more item while the result side stalls
// reset: asynchronous, idle mode with the transmit line high and buffers empty
`timescale 1ns / 1ps
module soft_uart_8n1_transceiver
	import stu_pkg::*;
#(
	parameter int TICKS_PER_BIT = TICKS_PER_BIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stu_req_if.sink   cmd,
	stu_res_if.source res
);

	stu_result_t result;
	logic        buf_ready;
	logic        accept;

	assign cmd.ready = buf_ready;
	assign accept    = cmd.valid && buf_ready;

	stu_core #(
		.TICKS_PER_BIT(TICKS_PER_BIT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (cmd.req_type),
		.tx_byte  (cmd.tx_byte),
		.rx_line  (cmd.rx_line),
		.result   (result)
	);

	stu_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (buf_ready),
		.in_data  (result),
		.res      (res)
	);

endmodule

// ===== rtl/stu_core.sv =====
// uart frame state and single-pass update for one item
`timescale 1ns / 1ps
module stu_core
	import stu_pkg::*;
#(
	parameter int TICKS_PER_BIT = TICKS_PER_BIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  req_type,
	input  logic [7:0]  tx_byte,
	input  logic        rx_line,
	output stu_result_t result
);

	localparam int TW = (TICKS_PER_BIT > 1) ? $clog2(TICKS_PER_BIT) : 1;
	localparam logic [TW-1:0] TICK_LAST = TW'(TICKS_PER_BIT - 1);

	mode_t         mode_q, mode_d;
	logic [TW-1:0] tick_q, tick_d;
	logic [3:0]    pos_q, pos_d;
	logic [7:0]    shift_q, shift_d;
	logic          line_q, line_d;

	logic          wrap;
	logic [3:0]    pos_inc;
	logic          tx_done, rx_done;
	logic [7:0]    rx_out;

	assign wrap    = (tick_q == TICK_LAST);
	assign pos_inc = (pos_q < POS_FRAME_END) ? pos_q + 4'd1 : pos_q;

	always_comb begin
		mode_d  = mode_q;
		tick_d  = tick_q;
		pos_d   = pos_q;
		shift_d = shift_q;
		line_d  = line_q;
		tx_done = 1'b0;
		rx_done = 1'b0;
		rx_out  = 8'd0;
		case (req_type)
			REQ_SEND: begin
				mode_d  = MODE_TX;
				shift_d = tx_byte;
				tick_d  = '0;
				pos_d   = POS_START;
				line_d  = 1'b0;
			end
			REQ_RECV: begin
				mode_d  = MODE_RX;
				shift_d = 8'd0;
				tick_d  = '0;
				pos_d   = POS_START;
				line_d  = 1'b1;
			end
			REQ_TICK: begin
				if (mode_q == MODE_TX) begin
					tick_d = wrap ? '0 : tick_q + TW'(1);
					if (wrap) begin
						pos_d = pos_inc;
						if (pos_inc >= POS_DATA_FIRST && pos_inc <= POS_DATA_LAST) begin
							line_d  = shift_q[0];
							shift_d = {1'b0, shift_q[7:1]};
						end else if (pos_inc == POS_STOP) begin
							line_d = 1'b1;
						end else begin
							line_d  = 1'b1;
							mode_d  = MODE_IDLE;
							pos_d   = POS_START;
							tx_done = 1'b1;
						end
					end
				end else if (mode_q == MODE_RX) begin
					if (pos_q == POS_START && rx_line) begin
						tick_d = '0;
					end else begin
						tick_d = wrap ? '0 : tick_q + TW'(1);
						if (wrap) begin
							pos_d = pos_inc;
							if (pos_inc >= POS_DATA_FIRST && pos_inc <= POS_DATA_LAST) begin
								shift_d = {rx_line, shift_q[7:1]};
							end else if (pos_inc >= POS_FRAME_END) begin
								rx_done = 1'b1;
								rx_out  = shift_q;
								mode_d  = MODE_IDLE;
								pos_d   = POS_START;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			tick_q  <= '0;
			pos_q   <= POS_START;
			shift_q <= 8'd0;
			line_q  <= 1'b1;
		end else if (accept) begin
			mode_q  <= mode_d;
			tick_q  <= tick_d;
			pos_q   <= pos_d;
			shift_q <= shift_d;
			line_q  <= line_d;
		end
	end

	assign result.tx_line  = line_d;
	assign result.tx_done  = tx_done;
	assign result.rx_done  = rx_done;
	assign result.rx_byte  = rx_out;
	assign result.mode_now = mode_d;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_FRAME_END)
		else $error("bit position beyond frame end");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> pos_q == POS_START && line_q)
		else $error("idle with frame position or low line");

	a_send_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_SEND |=> mode_q == MODE_TX && !line_q && tick_q == '0)
		else $error("send request did not start a frame");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= TICK_LAST)
		else $error("tick count out of range");

endmodule

// ===== rtl/stu_out_buf.sv =====
// result register with skid stage
`timescale 1ns / 1ps
module stu_out_buf
	import stu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  stu_result_t in_data,
	stu_res_if.source   res
);

	logic        out_valid_q, skid_valid_q;
	stu_result_t out_q, skid_q;
	logic        take, push;

	assign in_ready = !skid_valid_q;
	assign push     = in_valid && in_ready;
	assign take     = out_valid_q && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (out_valid_q && !take) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.tx_line  = out_q.tx_line;
	assign res.tx_done  = out_q.tx_done;
	assign res.rx_done  = out_q.rx_done;
	assign res.rx_byte  = out_q.rx_byte;
	assign res.mode_now = out_q.mode_now;

endmodule

// ===== sim/soft_uart_8n1_transceiver_test.sv =====
// self-checking testbench for the half-duplex 8n1 uart transceiver
`timescale 1ns / 1ps
module soft_uart_8n1_transceiver_test;
	import stu_pkg::*;

	localparam int TPB = TICKS_PER_BIT_DEF;
	localparam int FRAME_TICKS = 10 * TPB;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int SIDE_CMD = 0;
	localparam int SIDE_RES = 1;

	class uart_scoreboard;
		mode_t mode;
		int unsigned tick_cnt;
		logic [3:0] bit_pos;
		logic [7:0] shreg;
		logic line;
		stu_result_t expected_q[$];
		int errors;
		int checked;
		int tx_frames;
		int rx_frames;

		function new();
			mode = MODE_IDLE;
			tick_cnt = 0;
			bit_pos = POS_START;
			shreg = '0;
			line = 1'b1;
			errors = 0;
			checked = 0;
			tx_frames = 0;
			rx_frames = 0;
		endfunction

		// one tick inside a bit, true when a bit boundary passes
		function bit cross_bit();
			tick_cnt++;
			if (tick_cnt >= TPB) begin
				tick_cnt = 0;
				if (bit_pos < POS_FRAME_END)
					bit_pos++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(logic [1:0] req, logic [7:0] tx_data, logic rx_pin);
			stu_result_t r;
			r = '0;
			case (req)
				REQ_SEND: begin
					mode = MODE_TX;
					shreg = tx_data;
					tick_cnt = 0;
					bit_pos = POS_START;
					line = 1'b0;
				end
				REQ_RECV: begin
					mode = MODE_RX;
					shreg = '0;
					tick_cnt = 0;
					bit_pos = POS_START;
					line = 1'b1;
				end
				REQ_TICK: begin
					if (mode == MODE_TX) begin
						if (cross_bit()) begin
							if (bit_pos >= POS_DATA_FIRST && bit_pos <= POS_DATA_LAST) begin
								line = shreg[0];
								shreg = shreg >> 1;
							end else if (bit_pos == POS_STOP) begin
								line = 1'b1;
							end else begin
								line = 1'b1;
								mode = MODE_IDLE;
								bit_pos = POS_START;
								r.tx_done = 1'b1;
								tx_frames++;
							end
						end
					end else if (mode == MODE_RX) begin
						// start hunting: a high line restarts the count
						if (bit_pos == POS_START && rx_pin) begin
							tick_cnt = 0;
						end else if (cross_bit()) begin
							if (bit_pos >= POS_DATA_FIRST && bit_pos <= POS_DATA_LAST) begin
								shreg = {rx_pin, shreg[7:1]};
							end else if (bit_pos >= POS_FRAME_END) begin
								r.rx_done = 1'b1;
								r.rx_byte = shreg;
								mode = MODE_IDLE;
								bit_pos = POS_START;
								rx_frames++;
							end
						end
					end
				end
				default: ;
			endcase
			r.tx_line = line;
			r.mode_now = mode;
			expected_q.push_back(r);
		endfunction

		function void check_result(stu_result_t got);
			stu_result_t exp;
			if (expected_q.size() == 0) begin
				$error("result with no item pending: %p", got);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			if (got.tx_line !== exp.tx_line) begin
				$error("tx_line expected %0d actual %0d", exp.tx_line, got.tx_line);
				errors++;
			end
			if (got.tx_done !== exp.tx_done) begin
				$error("tx_done expected %0d actual %0d", exp.tx_done, got.tx_done);
				errors++;
			end
			if (got.rx_done !== exp.rx_done) begin
				$error("rx_done expected %0d actual %0d", exp.rx_done, got.rx_done);
				errors++;
			end
			if (got.rx_byte !== exp.rx_byte) begin
				$error("rx_byte expected 0x%02h actual 0x%02h", exp.rx_byte, got.rx_byte);
				errors++;
			end
			if (got.mode_now !== exp.mode_now) begin
				$error("mode_now expected %0d actual %0d", exp.mode_now, got.mode_now);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int stretch_left[2] = '{0, 0};
	bit calm[2] = '{1'b0, 1'b0};
	uart_scoreboard sb = new();

	stu_req_if cmd_ch();
	stu_res_if res_ch();

	soft_uart_8n1_transceiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL soft_uart_8n1_transceiver");
			$finish;
		end
	end

	// stretches of back-to-back items alternate with random gaps
	function automatic int draw_gap(int side);
		if (stretch_left[side] == 0) begin
			stretch_left[side] = $urandom_range(10, 60);
			calm[side] = ($urandom_range(0, 3) == 0);
		end
		stretch_left[side]--;
		return calm[side] ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic push_item(logic [1:0] req, logic [7:0] tx_data, logic rx_pin);
		int gap;
		gap = draw_gap(SIDE_CMD);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.req_type <= req;
		cmd_ch.tx_byte <= tx_data;
		cmd_ch.rx_line <= rx_pin;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_item(req, tx_data, rx_pin);
		if (req != REQ_UNUSED)
			items_sent++;
	endtask

	task automatic push_tick(logic rx_pin);
		if ($urandom_range(0, 24) == 0)
			push_item(REQ_UNUSED, 8'($urandom), 1'($urandom));
		push_item(REQ_TICK, 8'($urandom), rx_pin);
	endtask

	task automatic send_frame();
		int total;
		total = FRAME_TICKS + $urandom_range(0, 4);
		// cut short now and then so the next request aborts the frame
		if ($urandom_range(0, 5) == 0)
			total = $urandom_range(1, FRAME_TICKS - 1);
		push_item(REQ_SEND, 8'($urandom), 1'($urandom));
		repeat (total) push_tick(1'($urandom));
	endtask

	task automatic receive_frame();
		logic [7:0] data;
		logic [9:0] wave;
		int total;
		data = 8'($urandom);
		wave = {1'b1, data, 1'b0};
		push_item(REQ_RECV, 8'($urandom), 1'($urandom));
		repeat ($urandom_range(0, 6)) push_tick(1'b1);
		// false start bit
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, TPB - 1)) push_tick(1'b0);
			push_tick(1'b1);
		end
		total = FRAME_TICKS + $urandom_range(0, 4);
		if ($urandom_range(0, 5) == 0)
			total = $urandom_range(1, FRAME_TICKS - 1);
		for (int n = 0; n < total; n++)
			push_tick((n < FRAME_TICKS) ? wave[n / TPB] : 1'b1);
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			int gap;
			gap = draw_gap(SIDE_RES);
			// long hold-off so the result buffer fills and the request side stalls
			if (results_seen == HOLD_AT_RESULT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			results_seen++;
			sb.check_result('{tx_line: res_ch.tx_line, tx_done: res_ch.tx_done,
				rx_done: res_ch.rx_done, rx_byte: res_ch.rx_byte,
				mode_now: res_ch.mode_now});
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.req_type <= REQ_TICK;
		cmd_ch.tx_byte <= '0;
		cmd_ch.rx_line <= 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks and the unused request code
		push_item(REQ_TICK, 8'h00, 1'b0);
		push_item(REQ_TICK, 8'hff, 1'b1);
		push_item(REQ_UNUSED, 8'hff, 1'b1);
		push_item(REQ_UNUSED, 8'h00, 1'b0);
		// send, then abort it with another send and then a receive
		push_item(REQ_SEND, 8'h00, 1'b1);
		repeat (TPB) push_item(REQ_TICK, 8'hff, 1'b0);
		push_item(REQ_UNUSED, 8'h5a, 1'b1);
		push_item(REQ_SEND, 8'hff, 1'b0);
		repeat (2) push_item(REQ_TICK, 8'h00, 1'b1);
		push_item(REQ_RECV, 8'hff, 1'b1);
		repeat (2) push_item(REQ_TICK, 8'h00, 1'b1);
		repeat (3) push_item(REQ_TICK, 8'h00, 1'b0);
		push_item(REQ_TICK, 8'h00, 1'b1);
		repeat (2) push_item(REQ_TICK, 8'h00, 1'b0);
		// send aborts the receive
		push_item(REQ_SEND, 8'ha5, 1'b0);
		push_item(REQ_TICK, 8'h00, 1'b0);

		while (items_sent < 500) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_frame();
				4, 5, 6, 7: receive_frame();
				default: begin
					repeat ($urandom_range(5, 20))
						push_item(2'($urandom), 8'($urandom), 1'($urandom));
				end
			endcase
		end

		cmd_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d requests driven, %0d results checked", items_sent, sb.checked);
		$display("%0d frames sent and %0d received complete, one long result stall",
			sb.tx_frames, sb.rx_frames);
		if (sb.errors == 0)
			$display("PASS soft_uart_8n1_transceiver");
		else
			$display("FAIL soft_uart_8n1_transceiver");
		$finish;
	end

endmodule

// ===== soft_uart_8n1_transceiver.f =====
rtl/stu_pkg.sv
rtl/stu_req_if.sv
rtl/stu_res_if.sv
rtl/stu_core.sv
rtl/stu_out_buf.sv
rtl/soft_uart_8n1_transceiver.sv
sim/soft_uart_8n1_transceiver_test.sv
